// ===== rtl/spv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample playback voice package
// Request and register codes, pitch and velocity tables, and the datapath
// control word that passes between the voice controller and the mixer.
// ----------------------------------------------------------------------------
package spv_pkg;

  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd2;
  localparam logic [1:0] REQ_TICK     = 2'd3;

  localparam logic [1:0] CFG_LOOP_MODE     = 2'd0;
  localparam logic [1:0] CFG_VOLUME        = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_LENGTH = 2'd2;

  localparam logic [15:0] UNITY_GAIN = 16'd32768;

  typedef logic [16:0] semitone_tbl_t [12];
  typedef logic [15:0] gain_tbl_t [128];

  localparam semitone_tbl_t SEMITONE_Q16 = '{
    17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
    17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
  };

  function automatic gain_tbl_t build_gain_table();
    gain_tbl_t tbl;
    for (int i = 0; i < 128; i++) begin
      tbl[i] = 16'((i * 32768 + 63) / 127);
    end
    return tbl;
  endfunction

  localparam gain_tbl_t VELOCITY_GAIN = build_gain_table();

  typedef struct packed {
    logic ld_product;
    logic ld_scaled;
  } spv_ctl_t;

endpackage

// ===== rtl/spv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/spv_note.sv =====
// ----------------------------------------------------------------------------
// Note-on decoder
// Derives the fractional phase step from the note number and the Q1.15
// velocity gain from the velocity.
// ----------------------------------------------------------------------------
module spv_note import spv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic [6:0]           note,
  input  logic [6:0]           velocity,
  output logic [FRAC_BITS+5:0] step,
  output logic [15:0]          gain
);

  localparam int TW = FRAC_BITS + 22;

  logic [3:0]    octave;
  logic [6:0]    semi_full;
  logic [3:0]    semi;
  logic [4:0]    shift_amt;
  logic [TW-1:0] scaled;
  logic [TW-1:0] shifted;
  logic [TW-1:0] rounded;

  always_comb begin
    octave = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (note >= 7'(12 * k)) begin
        octave = 4'(k);
      end
    end
  end

  assign semi_full = note - (7'(octave) * 7'd12);
  assign semi      = semi_full[3:0];
  assign shift_amt = 5'd25 - 5'(octave);
  assign scaled    = TW'(SEMITONE_Q16[semi]) << (FRAC_BITS + 5);
  assign shifted   = scaled >> shift_amt;
  assign rounded   = (shifted + TW'(1)) >> 1;
  assign step      = rounded[FRAC_BITS+5:0];
  assign gain      = VELOCITY_GAIN[velocity];

endmodule

// ===== rtl/spv_mix.sv =====
// ----------------------------------------------------------------------------
// Voice mixer datapath
// Two registered multiplies (sample by gain, then by volume), rounding and
// a saturating add onto the incoming mix sample.
// ----------------------------------------------------------------------------
module spv_mix import spv_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  spv_ctl_t                      ctl,
  input  logic signed [SAMPLE_BITS-1:0] word,
  input  logic [15:0]                   gain,
  input  logic [15:0]                   volume,
  input  logic signed [15:0]            mix_val,
  input  logic                          play,
  output logic signed [15:0]            mixed_sum
);

  localparam int P1W = SAMPLE_BITS + 17;
  localparam int P2W = SAMPLE_BITS + 34;
  localparam int SH  = SAMPLE_BITS + 14;
  localparam logic signed [P2W-1:0] HALF = P2W'(1) << (SH - 1);

  logic signed [P1W-1:0] product;
  logic signed [P2W-1:0] scaled;
  logic [15:0]           vol_clamped;
  logic signed [P2W-1:0] shifted;
  logic signed [16:0]    contrib;
  logic signed [17:0]    sum;

  assign vol_clamped = (volume > UNITY_GAIN) ? UNITY_GAIN : volume;

  always_ff @(posedge clk) begin
    if (ctl.ld_product) begin
      product <= word * $signed({1'b0, gain});
    end
    if (ctl.ld_scaled) begin
      scaled <= product * $signed({1'b0, vol_clamped});
    end
  end

  assign shifted = (scaled + HALF) >>> SH;
  assign contrib = play ? shifted[16:0] : 17'sd0;
  assign sum     = $signed({{2{mix_val[15]}}, mix_val}) + $signed({contrib[16], contrib});

  always_comb begin
    priority if (sum > 18'sd32767) begin
      mixed_sum = 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      mixed_sum = 16'sh8000;
    end else begin
      mixed_sum = sum[15:0];
    end
  end

endmodule

// ===== rtl/sample_playback_voice.sv =====
// ----------------------------------------------------------------------------
// Sample playback voice
// One voice reading signed samples from on-chip memory through a fractional
// phase accumulator, scaled by velocity and volume and mixed onto an input.
// ----------------------------------------------------------------------------
// Load, note-on and note-off items complete on transfer, and the next item is
// accepted in the following cycle. A tick item on a playing voice passes from
// its transfer through the sample memory read, the sample-by-gain multiply and
// the volume multiply, with rounding and saturation ahead of the output
// register, to its result being registered at the output. Input is accepted
// again in the cycle after, so the voice takes no new item while a tick is in
// progress. A tick on an idle voice, or on the tick where the voice stops,
// skips the read and multiply states and registers its result from the output
// state. A result that has not been taken only delays a later tick in its
// final step. The sample memory needs no clearing after reset; playing words
// that were never loaded gives undefined output.
module sample_playback_voice import spv_pkg::*; #(
  parameter int SAMPLE_ADDR_BITS = 16,
  parameter int SAMPLE_BITS      = 16,
  parameter int FRAC_BITS        = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [15:0]        load_address,
  input  logic signed [15:0] load_data,
  input  logic [6:0]         note,
  input  logic [6:0]         velocity,
  input  logic signed [15:0] mix_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] mixed,
  output logic               voice_active
);

  localparam int PW = FRAC_BITS + 22;
  localparam int SW = FRAC_BITS + 6;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]    state;
  logic          loop_mode;
  logic [15:0]   volume;
  logic [16:0]   sample_length;
  logic [PW-1:0] phase;
  logic [SW-1:0] step;
  logic [15:0]   gain;
  logic          voice_on;

  logic                          in_fire;
  logic                          out_load;
  logic [21:0]                   pos;
  logic                          at_end;
  logic                          wrap;
  logic                          tick_play;
  logic [PW-1:0]                 tick_base;
  logic [SAMPLE_ADDR_BITS-1:0]   rd_addr;
  logic                          rd_en;
  logic                          wr_en;
  logic [SAMPLE_BITS-1:0]        wr_word;
  logic signed [SAMPLE_BITS-1:0] rd_word;
  logic [SW-1:0]                 note_step;
  logic [15:0]                   note_gain;
  logic signed [15:0]            mix_hold;
  logic                          play;
  logic signed [15:0]            mixed_sum;
  spv_ctl_t                      ctl;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == ST_OUT) && (!out_valid || out_ready);

  assign pos       = phase[FRAC_BITS +: 22];
  assign at_end    = pos >= 22'(sample_length);
  assign wrap      = loop_mode && (sample_length != 17'd0);
  assign tick_play = voice_on && (!at_end || wrap);
  assign tick_base = at_end ? '0 : phase;
  assign rd_addr   = at_end ? '0 : SAMPLE_ADDR_BITS'(pos);
  assign rd_en     = in_fire && (req_type == REQ_TICK);
  assign wr_en     = in_fire && (req_type == REQ_LOAD);

  generate
    if (SAMPLE_BITS >= 16) begin : g_word_wide
      assign wr_word = SAMPLE_BITS'(load_data) << (SAMPLE_BITS - 16);
    end else begin : g_word_narrow
      assign wr_word = load_data[15 -: SAMPLE_BITS];
    end
  endgenerate

  assign ctl.ld_product = (state == ST_RD);
  assign ctl.ld_scaled  = (state == ST_MUL);

  spv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (1 << SAMPLE_ADDR_BITS)
  ) u_sample_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (SAMPLE_ADDR_BITS'(load_address)),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  spv_note #(
    .FRAC_BITS (FRAC_BITS)
  ) u_note (
    .note     (note),
    .velocity (velocity),
    .step     (note_step),
    .gain     (note_gain)
  );

  spv_mix #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .clk       (clk),
    .ctl       (ctl),
    .word      (rd_word),
    .gain      (gain),
    .volume    (volume),
    .mix_val   (mix_hold),
    .play      (play),
    .mixed_sum (mixed_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode     <= 1'b0;
      volume        <= UNITY_GAIN;
      sample_length <= 17'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOOP_MODE:     loop_mode     <= cfg_data[0];
        CFG_VOLUME:        volume        <= cfg_data[15:0];
        CFG_SAMPLE_LENGTH: sample_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= '0;
      step      <= '0;
      gain      <= 16'd0;
      voice_on  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (req_type)
              REQ_LOAD: ;
              REQ_NOTE_ON: begin
                if (sample_length != 17'd0) begin
                  phase    <= '0;
                  step     <= note_step;
                  gain     <= note_gain;
                  voice_on <= 1'b1;
                end
              end
              REQ_NOTE_OFF: begin
                if (!loop_mode) begin
                  voice_on <= 1'b0;
                end
              end
              REQ_TICK: begin
                voice_on <= tick_play;
                if (tick_play) begin
                  phase <= tick_base + PW'(step);
                  state <= ST_RD;
                end else begin
                  state <= ST_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_RD:  state <= ST_MUL;
        ST_MUL: state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mix_hold <= mix_in;
      play     <= tick_play;
    end
    if (out_load) begin
      mixed        <= mixed_sum;
      voice_active <= play;
    end
  end

endmodule

// ===== rtl/spv_checker.sv =====
// ----------------------------------------------------------------------------
// Sample playback voice checker
// Port-level checks on item timing and result stability, bound to the top.
// ----------------------------------------------------------------------------
module spv_checker import spv_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] mixed,
  input logic               voice_active
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mixed) && $stable(voice_active))
    else $error("Result changed while stalled.");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == REQ_TICK |=> !in_ready)
    else $error("Input accepted while a tick was in progress.");

  a_short_items: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type != REQ_TICK |=> in_ready)
    else $error("Non-tick item did not complete in one cycle.");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("Result appeared without a tick in progress.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Output valid after reset.");

endmodule

bind sample_playback_voice spv_checker u_spv_checker (.*);
